/* src/envelope_follower_with_sample_ring_macros.svh */
// Assertion macros shared by the verification files of the envelope follower.
// Depends on nothing; each macro expects signals clk and rst_n in scope.
`ifndef ENVELOPE_FOLLOWER_WITH_SAMPLE_RING_MACROS_SVH
`define ENVELOPE_FOLLOWER_WITH_SAMPLE_RING_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define EFSR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define EFSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/efsr_pkg.sv */
// Shared types, constants and helpers for the envelope follower with sample ring.
// Used by every RTL module of the block; depends on nothing.
package efsr_pkg;

  localparam int unsigned RING_DEPTH = 256;
  localparam int unsigned PTR_W      = $clog2(RING_DEPTH);
  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned ENV_W      = 11;
  localparam int unsigned CALC_W     = 12;
  localparam int unsigned CFG_IDX_W  = 2;

  typedef logic [PTR_W-1:0]           ptr_t;
  typedef logic [SAMPLE_W-1:0]        sample_t;
  typedef logic signed [ENV_W-1:0]    env_t;
  typedef logic signed [CALC_W-1:0]   calc_t;

  localparam ptr_t LAST_PTR = ptr_t'(RING_DEPTH - 1);

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DECAY_RATE     = 2'd0,
    REG_TRIGGER_ENABLE = 2'd1,
    REG_TRIGGER_LEVEL  = 2'd2,
    REG_RELEASE_LEVEL  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    sample_t decay_rate;
    logic    trigger_enable;
    sample_t trigger_level;
    sample_t release_level;
  } cfg_t;

  typedef struct packed {
    env_t envelope;
    logic fired;
  } env_res_t;

  typedef struct packed {
    logic overwrote;
    logic read_valid;
  } ring_res_t;

  function automatic ptr_t ptr_inc(ptr_t p);
    return (p == LAST_PTR) ? '0 : ptr_t'(p + 1'b1);
  endfunction

endpackage

/* src/efsr_env.sv */
// Peak envelope tracker with decay and hysteresis trigger.
// Depends on efsr_pkg; updates its state in the cycle a sample request is taken.
module efsr_env (
  input  logic                clk,
  input  logic                rst_n,
  input  efsr_pkg::cfg_t      cfg,
  input  logic                upd,
  input  efsr_pkg::sample_t   sample,
  output efsr_pkg::env_res_t  res
);

  efsr_pkg::env_t  env_r, env_nxt;
  logic            latched_r, latched_nxt;
  efsr_pkg::calc_t smp_ext, env_ext, dec_ext, trig_ext, rel_ext, env_calc;
  logic            fire;

  always_comb begin
    smp_ext  = $signed({{(efsr_pkg::CALC_W - efsr_pkg::SAMPLE_W){1'b0}}, sample});
    env_ext  = $signed({env_r[efsr_pkg::ENV_W-1], env_r});
    dec_ext  = $signed({{(efsr_pkg::CALC_W - efsr_pkg::SAMPLE_W){1'b0}}, cfg.decay_rate});
    trig_ext = $signed({{(efsr_pkg::CALC_W - efsr_pkg::SAMPLE_W){1'b0}}, cfg.trigger_level});
    rel_ext  = $signed({{(efsr_pkg::CALC_W - efsr_pkg::SAMPLE_W){1'b0}}, cfg.release_level});

    // Samples are never negative, so the envelope stays within 11 signed bits.
    env_calc = (smp_ext >= env_ext) ? smp_ext : efsr_pkg::calc_t'(env_ext - dec_ext);

    fire        = 1'b0;
    latched_nxt = latched_r;
    if (cfg.trigger_enable) begin
      if (env_calc >= trig_ext) begin
        fire        = !latched_r;
        latched_nxt = 1'b1;
      end else if (env_calc <= rel_ext) begin
        latched_nxt = 1'b0;
      end
    end

    env_nxt      = env_calc[efsr_pkg::ENV_W-1:0];
    res.envelope = upd ? env_nxt : env_r;
    res.fired    = upd & fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      env_r     <= '0;
      latched_r <= 1'b0;
    end else if (upd) begin
      env_r     <= env_nxt;
      latched_r <= latched_nxt;
    end
  end

endmodule

/* src/efsr_ring.sv */
// Overwrite-oldest sample ring: pointers, full flag and sample memory.
// Depends on efsr_pkg; read data is registered and appears in the cycle after the read request.
module efsr_ring (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_req,
  input  logic                 rd_req,
  input  efsr_pkg::sample_t    sample,
  output efsr_pkg::ring_res_t  res,
  output efsr_pkg::sample_t    rd_data
);

  efsr_pkg::sample_t mem_q [efsr_pkg::RING_DEPTH];
  efsr_pkg::ptr_t    wp_r, wp_nxt, rp_r, rp_nxt;
  logic              full_r, full_nxt;
  logic              nonempty, rd_en;

  always_comb begin
    nonempty = full_r || (rp_r != wp_r);
    rd_en    = rd_req && nonempty;
    wp_nxt   = wp_r;
    rp_nxt   = rp_r;
    full_nxt = full_r;
    res.overwrote  = 1'b0;
    res.read_valid = 1'b0;
    if (wr_req) begin
      // A full ring drops its oldest entry to make room.
      res.overwrote = full_r;
      if (full_r) begin
        rp_nxt = efsr_pkg::ptr_inc(rp_r);
      end
      wp_nxt   = efsr_pkg::ptr_inc(wp_r);
      full_nxt = (wp_nxt == rp_nxt);
    end else if (rd_en) begin
      res.read_valid = 1'b1;
      rp_nxt   = efsr_pkg::ptr_inc(rp_r);
      full_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      full_r <= 1'b0;
    end else begin
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      full_r <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_req) begin
      mem_q[wp_r] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_q[rp_r];
    end
  end

endmodule

/* src/envelope_follower_with_sample_ring.sv */
// Top level of the envelope follower with sample ring: config registers,
// request stage and output register. Depends on efsr_pkg, efsr_env, efsr_ring.
//
//   channel  | ports                                   | direction
//   ---------+-----------------------------------------+----------
//   request  | in_valid/in_ready, in_kind, in_sample   | in
//   result   | out_valid/out_ready, out_envelope, ...  | out
//   config   | cfg_valid/cfg_ready, cfg_index, cfg_data| in
//
// One request per cycle while in_ready is high; a result is held in the request stage
// and the registered read port of the sample memory, then in the output register.
// Reset is synchronous; the ring comes out empty and needs no clearing pass.
// The request stage and the output register hold two results, so a stalled
// result does not block the next request; config writes are always taken.
module envelope_follower_with_sample_ring (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_kind,
  input  logic [efsr_pkg::SAMPLE_W-1:0] in_sample,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [efsr_pkg::ENV_W-1:0] out_envelope,
  output logic                         out_trigger_fired,
  output logic [efsr_pkg::SAMPLE_W-1:0] out_read_data,
  output logic                         out_read_valid,
  output logic                         out_overwrote,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [efsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [efsr_pkg::SAMPLE_W-1:0] cfg_data
);

  efsr_pkg::cfg_t      cfg_r;
  efsr_pkg::env_res_t  env_res, s1_env_r;
  efsr_pkg::ring_res_t ring_res, s1_ring_r;
  efsr_pkg::sample_t   ring_rd_data;
  logic                acc, acc_smp, acc_rd, s1_go;
  logic                s1_valid_r, s1_valid_nxt, out_valid_r, out_valid_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.decay_rate     <= efsr_pkg::sample_t'(1);
      cfg_r.trigger_enable <= 1'b0;
      cfg_r.trigger_level  <= '0;
      cfg_r.release_level  <= '0;
    end else if (cfg_valid) begin
      unique case (efsr_pkg::cfg_idx_t'(cfg_index))
        efsr_pkg::REG_DECAY_RATE:     cfg_r.decay_rate     <= cfg_data;
        efsr_pkg::REG_TRIGGER_ENABLE: cfg_r.trigger_enable <= cfg_data[0];
        efsr_pkg::REG_TRIGGER_LEVEL:  cfg_r.trigger_level  <= cfg_data;
        efsr_pkg::REG_RELEASE_LEVEL:  cfg_r.release_level  <= cfg_data;
        default: ;
      endcase
    end
  end

  // The request stage moves on whenever the output register is free or drained.
  assign s1_go    = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_go;
  assign acc      = in_valid && in_ready;
  assign acc_smp  = acc && (in_kind == efsr_pkg::KIND_SAMPLE);
  assign acc_rd   = acc && (in_kind == efsr_pkg::KIND_READ);

  efsr_env u_env (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .upd    (acc_smp),
    .sample (in_sample),
    .res    (env_res)
  );

  efsr_ring u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_req  (acc_smp),
    .rd_req  (acc_rd),
    .sample  (in_sample),
    .res     (ring_res),
    .rd_data (ring_rd_data)
  );

  always_comb begin
    s1_valid_nxt  = acc ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_go ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_env_r  <= env_res;
      s1_ring_r <= ring_res;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_go) begin
      out_envelope      <= s1_env_r.envelope;
      out_trigger_fired <= s1_env_r.fired;
      out_read_data     <= s1_ring_r.read_valid ? ring_rd_data : '0;
      out_read_valid    <= s1_ring_r.read_valid;
      out_overwrote     <= s1_ring_r.overwrote;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* src/efsr_checker.sv */
// Port-level checks for the envelope follower with sample ring, bound to the top.
// Depends on efsr_pkg and the shared assertion macro header.
`include "envelope_follower_with_sample_ring_macros.svh"

module efsr_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [efsr_pkg::ENV_W-1:0] out_envelope,
  input logic                           out_trigger_fired,
  input logic [efsr_pkg::SAMPLE_W-1:0]  out_read_data,
  input logic                           out_read_valid,
  input logic                           out_overwrote
);

  // A read result never carries sample-side flags.
  `EFSR_ASSERT_NOW(a_read_flags, out_valid && out_read_valid, !out_overwrote && !out_trigger_fired, "read result with sample flags")
  `EFSR_ASSERT_NOW(a_read_zero, out_valid && !out_read_valid, out_read_data == '0, "read data without a stored sample")
  // The trigger level is never negative, so a firing envelope is not either.
  `EFSR_ASSERT_NOW(a_fire_sign, out_valid && out_trigger_fired, !out_envelope[efsr_pkg::ENV_W-1], "trigger fired on negative envelope")
  // With the output register empty the request stage can always drain.
  `EFSR_ASSERT_NOW(a_ready_free, !out_valid, in_ready, "request stalled with empty output")
  `EFSR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_envelope), "stalled result changed")

endmodule

bind envelope_follower_with_sample_ring efsr_checker u_efsr_checker (.*);

/* verif/efsr_result_checker.sv */
`timescale 1ns / 100ps
// Result checker for the envelope follower with sample ring: tracks register writes,
// predicts one result per accepted request and compares it with the result channel.
// Depends on efsr_pkg for widths, codes and the register index type.
module efsr_result_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                in_kind,
  input  logic [efsr_pkg::SAMPLE_W-1:0]       in_sample,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [efsr_pkg::ENV_W-1:0]   out_envelope,
  input  logic                                out_trigger_fired,
  input  logic [efsr_pkg::SAMPLE_W-1:0]       out_read_data,
  input  logic                                out_read_valid,
  input  logic                                out_overwrote,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [efsr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [efsr_pkg::SAMPLE_W-1:0]       cfg_data,
  output int                                  mismatches,
  output int                                  outstanding
);

  typedef struct {
    logic signed [efsr_pkg::ENV_W-1:0] envelope;
    logic                              fired;
    efsr_pkg::sample_t                 read_data;
    logic                              read_valid;
    logic                              overwrote;
  } follower_result_t;

  follower_result_t upcoming[$];

  efsr_pkg::sample_t decay;
  logic              trig_on;
  efsr_pkg::sample_t trig_level;
  efsr_pkg::sample_t rel_level;

  int                env_level;
  logic              latched;
  efsr_pkg::sample_t ring [efsr_pkg::RING_DEPTH];
  efsr_pkg::ptr_t    wr_ptr;
  efsr_pkg::ptr_t    rd_ptr;
  logic              ring_full;
  int                errors = 0;

  function automatic efsr_pkg::ptr_t advance(efsr_pkg::ptr_t p);
    return efsr_pkg::ptr_t'((int'(p) + 1) % efsr_pkg::RING_DEPTH);
  endfunction

  // Applies one request to the tracked state and returns the result it must produce.
  function automatic follower_result_t follow_item(logic kind, efsr_pkg::sample_t s);
    follower_result_t r;
    r = '{envelope: '0, fired: 1'b0, read_data: '0, read_valid: 1'b0, overwrote: 1'b0};
    if (kind == efsr_pkg::KIND_SAMPLE) begin
      if (int'(s) >= env_level) begin
        env_level = int'(s);
      end else begin
        env_level -= int'(decay);
      end
      ring[wr_ptr] = s;
      if (ring_full) begin
        r.overwrote = 1'b1;
        rd_ptr = advance(rd_ptr);
      end
      wr_ptr = advance(wr_ptr);
      ring_full = (wr_ptr == rd_ptr);
      if (trig_on) begin
        if (env_level >= int'(trig_level)) begin
          if (!latched) begin
            latched = 1'b1;
            r.fired = 1'b1;
          end
        end else if (env_level <= int'(rel_level)) begin
          latched = 1'b0;
        end
      end
    end else if (ring_full || rd_ptr != wr_ptr) begin
      r.read_data = ring[rd_ptr];
      r.read_valid = 1'b1;
      rd_ptr = advance(rd_ptr);
      ring_full = 1'b0;
    end
    r.envelope = env_level[efsr_pkg::ENV_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("[%0t] result mismatch: %s", $time, what);
  endtask

  always @(posedge clk) begin
    follower_result_t want;
    if (!rst_n) begin
      decay      = efsr_pkg::sample_t'(1);
      trig_on    = 1'b0;
      trig_level = '0;
      rel_level  = '0;
      env_level  = 0;
      latched    = 1'b0;
      wr_ptr     = '0;
      rd_ptr     = '0;
      ring_full  = 1'b0;
      upcoming.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (efsr_pkg::cfg_idx_t'(cfg_index))
          efsr_pkg::REG_DECAY_RATE:     decay = cfg_data;
          efsr_pkg::REG_TRIGGER_ENABLE: trig_on = cfg_data[0];
          efsr_pkg::REG_TRIGGER_LEVEL:  trig_level = cfg_data;
          efsr_pkg::REG_RELEASE_LEVEL:  rel_level = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        upcoming.push_back(follow_item(in_kind, in_sample));
      end
      if (out_valid && out_ready) begin
        if (upcoming.size() == 0) begin
          report_mismatch("result arrived with no request outstanding");
        end else begin
          want = upcoming.pop_front();
          if (out_envelope !== want.envelope)
            report_mismatch($sformatf("envelope %0d, expected %0d",
                                      int'(out_envelope), int'(want.envelope)));
          if (out_trigger_fired !== want.fired)
            report_mismatch($sformatf("trigger_fired %b, expected %b",
                                      out_trigger_fired, want.fired));
          if (out_read_data !== want.read_data)
            report_mismatch($sformatf("read_data %0d, expected %0d",
                                      out_read_data, want.read_data));
          if (out_read_valid !== want.read_valid)
            report_mismatch($sformatf("read_valid %b, expected %b",
                                      out_read_valid, want.read_valid));
          if (out_overwrote !== want.overwrote)
            report_mismatch($sformatf("overwrote %b, expected %b",
                                      out_overwrote, want.overwrote));
        end
      end
    end
    mismatches  <= errors;
    outstanding <= upcoming.size();
  end

endmodule

/* verif/tb_envelope_follower_with_sample_ring.sv */
`timescale 1ns / 100ps
// Testbench top for the envelope follower with sample ring: clock, reset, request,
// register and result-side stimulus, and the final verdict. Depends on efsr_pkg,
// efsr_result_checker and the block itself.
module tb_envelope_follower_with_sample_ring;

  localparam int CYCLE_LIMIT = 400000;

  logic                              clk;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic                              in_kind = efsr_pkg::KIND_SAMPLE;
  logic [efsr_pkg::SAMPLE_W-1:0]     in_sample = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic signed [efsr_pkg::ENV_W-1:0] out_envelope;
  logic                              out_trigger_fired;
  logic [efsr_pkg::SAMPLE_W-1:0]     out_read_data;
  logic                              out_read_valid;
  logic                              out_overwrote;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [efsr_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [efsr_pkg::SAMPLE_W-1:0]     cfg_data = '0;

  int          mismatches;
  int          outstanding;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit          rx_quiet = 1'b0;
  bit          tx_quiet = 1'b0;

  envelope_follower_with_sample_ring i_dut (.*);

  efsr_result_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Result side: random stalls, with quiet stretches where results are taken at once.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 300 == 0) rx_quiet <= ($urandom_range(0, 2) == 0);
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!rx_quiet && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      stall_left <= pick_gap() - 1;
    end else begin
      out_ready <= 1'b1;
    end
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_item(logic kind, efsr_pkg::sample_t s);
    int unsigned gap;
    gap = (tx_quiet || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_kind   <= kind;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  // The extra edge lets the checker count the request accepted on the last edge.
  task automatic wait_drained();
    @(posedge clk);
    wait (outstanding == 0);
  endtask

  task automatic write_reg(efsr_pkg::cfg_idx_t idx, efsr_pkg::sample_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(efsr_pkg::sample_t decay, logic en, efsr_pkg::sample_t tlevel,
                           efsr_pkg::sample_t rlevel);
    efsr_pkg::sample_t en_word;
    en_word = efsr_pkg::sample_t'($urandom);
    en_word[0] = en;
    wait_drained();
    write_reg(efsr_pkg::REG_DECAY_RATE, decay);
    write_reg(efsr_pkg::REG_TRIGGER_ENABLE, en_word);
    write_reg(efsr_pkg::REG_TRIGGER_LEVEL, tlevel);
    write_reg(efsr_pkg::REG_RELEASE_LEVEL, rlevel);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(efsr_pkg::sample_t decay, logic en, efsr_pkg::sample_t tlevel,
                           efsr_pkg::sample_t rlevel, int count, int read_pct);
    logic              kind;
    efsr_pkg::sample_t s;
    int unsigned       pick;
    configure(decay, en, tlevel, rlevel);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
      kind = ($urandom_range(0, 99) < read_pct) ? efsr_pkg::KIND_READ : efsr_pkg::KIND_SAMPLE;
      pick = $urandom_range(0, 9);
      s = efsr_pkg::sample_t'($urandom);
      if (pick == 0) begin
        s = '0;
      end else if (pick == 1) begin
        s = '1;
      end else if (pick < 6) begin
        s = efsr_pkg::sample_t'($urandom_range(0, 255));
      end
      send_item(kind, s);
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests: empty reads, extreme samples, decay, latch, re-arm and
    // an envelope that goes negative before the next sample lifts it.
    configure(efsr_pkg::sample_t'(100), 1'b1, efsr_pkg::sample_t'(600),
              efsr_pkg::sample_t'(200));
    send_item(efsr_pkg::KIND_READ, '0);
    send_item(efsr_pkg::KIND_SAMPLE, '0);
    send_item(efsr_pkg::KIND_SAMPLE, '1);
    send_item(efsr_pkg::KIND_SAMPLE, '1);
    send_item(efsr_pkg::KIND_SAMPLE, efsr_pkg::sample_t'(700));
    for (int i = 0; i < 5; i++) send_item(efsr_pkg::KIND_READ, '0);
    for (int i = 0; i < 10; i++) send_item(efsr_pkg::KIND_SAMPLE, '0);
    send_item(efsr_pkg::KIND_SAMPLE, efsr_pkg::sample_t'(600));
    send_item(efsr_pkg::KIND_READ, '1);
    in_valid <= 1'b0;

    run_phase('1, 1'b1, '1, '0, 100, 50);
    // Long run of samples so the ring fills and starts overwriting.
    run_phase('0, 1'b1, '0, '1, 300, 5);
    run_phase(efsr_pkg::sample_t'($urandom_range(20, 80)), 1'b1,
              efsr_pkg::sample_t'($urandom_range(600, 900)),
              efsr_pkg::sample_t'($urandom_range(150, 400)), 150, 80);
    run_phase(efsr_pkg::sample_t'($urandom), 1'b0, efsr_pkg::sample_t'($urandom),
              efsr_pkg::sample_t'($urandom), 100, 50);
    for (int p = 0; p < 4; p++) begin
      run_phase(($urandom_range(0, 3) == 0) ? efsr_pkg::sample_t'($urandom)
                                            : efsr_pkg::sample_t'($urandom_range(1, 60)),
                ($urandom_range(0, 1) == 1), efsr_pkg::sample_t'($urandom),
                efsr_pkg::sample_t'($urandom), 50, int'($urandom_range(10, 70)));
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
